### hw/rtl/hpr_pkg.sv
`timescale 1ns / 1ps

package hpr_pkg;

    // Field widths
    localparam int OP_W        = 2;
    localparam int FRAME_HI_W  = 6;
    localparam int FRAME_LO_W  = 4;
    localparam int FRAME_W     = FRAME_HI_W + FRAME_LO_W;
    localparam int KIND_W      = 32;
    localparam int IDENT_W     = 64;
    localparam int SID_W       = 32;
    localparam int SHORT_ID_W  = 16;
    localparam int MODE_W      = 2;
    localparam int TICK_W      = 7;

    // Default resync interval in ticks; valid range 1 to 127.
    localparam int RESYNC_INTERVAL_DEFAULT = 80;

    // Frame offset inside the 64-frame paging cycle above which the handset
    // stops listening.
    localparam logic [5:0] DEAF_OFFSET_MIN = 6'd55;

    // Item kinds
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_SYNC    = 2'd1;
    localparam logic [OP_W-1:0] OP_MESSAGE = 2'd2;

    // Control message kinds
    localparam logic [KIND_W-1:0] KIND_ACCEPT  = 32'd4;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 32'd5;
    localparam logic [KIND_W-1:0] KIND_PAGING  = 32'd100;

    // Connection modes as shown on the result word
    localparam logic [MODE_W-1:0] MODE_UNREG     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONNECTED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IDLE      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DONE      = 2'd3;

    // One result word
    typedef struct packed {
        logic               send_tune;
        logic               send_registration;
        logic               registered_event;
        logic               idle_event;
        logic               paged_event;
        logic [MODE_W-1:0]  connection_state;
        logic [FRAME_W-1:0] frame_count;
        logic               in_sync;
    } result_t;

endpackage

### hw/rtl/hpr_if.sv
`timescale 1ns / 1ps

// Input item channel
interface hpr_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [hpr_pkg::OP_W-1:0]               operation;
    logic [hpr_pkg::FRAME_HI_W-1:0]         frame_high_bits;
    logic [hpr_pkg::FRAME_LO_W-1:0]         frame_low_bits;
    logic [hpr_pkg::KIND_W-1:0]             message_kind;
    logic [hpr_pkg::IDENT_W-1:0]            message_identity;
    logic [hpr_pkg::SID_W-1:0]              message_short_id;

    modport source (
        output valid, operation, frame_high_bits, frame_low_bits,
               message_kind, message_identity, message_short_id,
        input  ready
    );
    modport sink (
        input  valid, operation, frame_high_bits, frame_low_bits,
               message_kind, message_identity, message_short_id,
        output ready
    );
endinterface

// Result channel
interface hpr_out_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   send_tune;
    logic                                   send_registration;
    logic                                   registered_event;
    logic                                   idle_event;
    logic                                   paged_event;
    logic [hpr_pkg::MODE_W-1:0]             connection_state;
    logic [hpr_pkg::FRAME_W-1:0]            frame_count;
    logic                                   in_sync;

    modport source (
        output valid, send_tune, send_registration, registered_event,
               idle_event, paged_event, connection_state, frame_count, in_sync,
        input  ready
    );
    modport sink (
        input  valid, send_tune, send_registration, registered_event,
               idle_event, paged_event, connection_state, frame_count, in_sync,
        output ready
    );
endinterface

// Configuration write channel
interface hpr_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [hpr_pkg::IDENT_W-1:0]            permanent_identity;

    modport source (
        output valid, permanent_identity,
        input  ready
    );
    modport sink (
        input  valid, permanent_identity,
        output ready
    );
endinterface

### hw/rtl/hpr_core.sv
`timescale 1ns / 1ps

// Handset state and the single-pass update for one accepted word.
module hpr_core #(
    parameter int RESYNC_INTERVAL = hpr_pkg::RESYNC_INTERVAL_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_accept,
    input  logic [hpr_pkg::OP_W-1:0]         operation,
    input  logic [hpr_pkg::FRAME_HI_W-1:0]   frame_high_bits,
    input  logic [hpr_pkg::FRAME_LO_W-1:0]   frame_low_bits,
    input  logic [hpr_pkg::KIND_W-1:0]       message_kind,
    input  logic [hpr_pkg::IDENT_W-1:0]      message_identity,
    input  logic [hpr_pkg::SID_W-1:0]        message_short_id,
    input  logic                             cfg_write,
    input  logic [hpr_pkg::IDENT_W-1:0]      cfg_identity,
    output hpr_pkg::result_t                 result
);

    localparam logic [hpr_pkg::TICK_W-1:0] RESYNC = hpr_pkg::TICK_W'(RESYNC_INTERVAL);

    logic                                synced_reg, synced_next;
    logic [hpr_pkg::FRAME_W-1:0]         frame_reg, frame_next;
    logic [hpr_pkg::TICK_W-1:0]          ticks_reg, ticks_next;
    logic [hpr_pkg::MODE_W-1:0]          mode_reg, mode_next;
    logic                                request_sent_reg, request_sent_next;
    logic [hpr_pkg::SHORT_ID_W-1:0]      short_id_reg, short_id_next;
    logic                                deaf_reg, deaf_next;
    logic [hpr_pkg::IDENT_W-1:0]         perm_id_reg;

    logic [hpr_pkg::FRAME_W-1:0]         rx_frame;
    logic                                sid_match;
    hpr_pkg::result_t                    res;

    assign rx_frame  = {frame_high_bits, frame_low_bits};
    assign sid_match = (message_short_id ==
                        {{(hpr_pkg::SID_W-hpr_pkg::SHORT_ID_W){1'b0}}, short_id_reg});

    // Next state and result for the word on the input.
    always_comb
    begin
        synced_next       = synced_reg;
        frame_next        = frame_reg;
        ticks_next        = ticks_reg;
        mode_next         = mode_reg;
        request_sent_next = request_sent_reg;
        short_id_next     = short_id_reg;
        deaf_next         = deaf_reg;
        res               = '0;

        if (mode_reg != hpr_pkg::MODE_DONE)
        begin
            case (operation)
                hpr_pkg::OP_TICK:
                begin
                    frame_next = frame_reg + 1'b1;
                    if (!synced_reg)
                    begin
                        res.send_tune = 1'b1;
                    end
                    else if (ticks_reg < RESYNC)
                    begin
                        ticks_next = ticks_reg + 1'b1;
                    end
                    deaf_next = (mode_reg == hpr_pkg::MODE_IDLE) &&
                                (frame_next[5:0] > hpr_pkg::DEAF_OFFSET_MIN) &&
                                (ticks_next < RESYNC);
                end
                hpr_pkg::OP_SYNC:
                begin
                    if (!deaf_reg)
                    begin
                        if (!synced_reg)
                        begin
                            frame_next  = rx_frame;
                            synced_next = 1'b1;
                            ticks_next  = '0;
                            if (!request_sent_reg && mode_reg == hpr_pkg::MODE_UNREG)
                            begin
                                res.send_registration = 1'b1;
                                request_sent_next     = 1'b1;
                            end
                        end
                        else if (ticks_reg >= RESYNC)
                        begin
                            frame_next = rx_frame;
                            ticks_next = '0;
                        end
                    end
                end
                hpr_pkg::OP_MESSAGE:
                begin
                    if (!deaf_reg)
                    begin
                        if (message_kind == hpr_pkg::KIND_ACCEPT)
                        begin
                            if (message_identity == perm_id_reg)
                            begin
                                short_id_next        = message_short_id[hpr_pkg::SHORT_ID_W-1:0];
                                mode_next            = hpr_pkg::MODE_CONNECTED;
                                res.registered_event = 1'b1;
                            end
                        end
                        else if (message_kind == hpr_pkg::KIND_RELEASE)
                        begin
                            if (sid_match && mode_reg == hpr_pkg::MODE_CONNECTED)
                            begin
                                mode_next      = hpr_pkg::MODE_IDLE;
                                res.idle_event = 1'b1;
                            end
                        end
                        else if (message_kind == hpr_pkg::KIND_PAGING)
                        begin
                            if (sid_match && mode_reg == hpr_pkg::MODE_IDLE)
                            begin
                                mode_next       = hpr_pkg::MODE_DONE;
                                res.paged_event = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    // Unused item kind leaves the state alone.
                end
            endcase
        end

        res.connection_state = mode_next;
        res.frame_count      = frame_next;
        res.in_sync          = synced_next;
    end

    assign result = res;

    // Handset state registers, updated once per accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg       <= 1'b0;
            frame_reg        <= '0;
            ticks_reg        <= '0;
            mode_reg         <= hpr_pkg::MODE_UNREG;
            request_sent_reg <= 1'b0;
            short_id_reg     <= '0;
            deaf_reg         <= 1'b0;
        end
        else if (item_accept)
        begin
            synced_reg       <= synced_next;
            frame_reg        <= frame_next;
            ticks_reg        <= ticks_next;
            mode_reg         <= mode_next;
            request_sent_reg <= request_sent_next;
            short_id_reg     <= short_id_next;
            deaf_reg         <= deaf_next;
        end
    end

    // Permanent identity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_id_reg <= '0;
        end
        else if (cfg_write)
        begin
            perm_id_reg <= cfg_identity;
        end
    end

endmodule

### hw/rtl/hpr_result_reg.sv
`timescale 1ns / 1ps

// Result register: holds one finished word until the sink takes it and
// accepts a new one in the same cycle the old one leaves.
module hpr_result_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  hpr_pkg::result_t result_in,
    input  logic             out_ready,
    output logic             can_load,
    output logic             out_valid,
    output hpr_pkg::result_t result_out
);

    logic             valid_reg, valid_next;
    hpr_pkg::result_t data_reg;

    assign can_load   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = data_reg;

    // Word is present after a load, gone once taken without a refill.
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

endmodule

### hw/rtl/handset_paging_receiver.sv
`timescale 1ns / 1ps

// Channel   Role    Word
// in_ch     sink    frame tick, sync burst or control message
// out_ch    source  events, connection state, frame number, sync flag
// cfg       sink    permanent identity
//
// Every input word gives one result word, shown on out_ch in the cycle after it is accepted.
// One word per cycle is sustained while out_ch.ready is high; the state update is one pass of logic
// between the handset state registers and the result register.
// in_ch.ready is low only while a result is held and out_ch.ready is low.
// Reset clears all state and the identity to zero; cfg.ready is always high.
module handset_paging_receiver #(
    parameter int RESYNC_INTERVAL = hpr_pkg::RESYNC_INTERVAL_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    hpr_in_if.sink    in_ch,
    hpr_out_if.source out_ch,
    hpr_cfg_if.sink   cfg
);

    logic             item_accept;
    logic             can_load;
    hpr_pkg::result_t core_result;
    hpr_pkg::result_t held_result;

    assign in_ch.ready = can_load;
    assign item_accept = in_ch.valid && can_load;
    assign cfg.ready   = 1'b1;

    // State update
    hpr_core #(
        .RESYNC_INTERVAL (RESYNC_INTERVAL)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_accept      (item_accept),
        .operation        (in_ch.operation),
        .frame_high_bits  (in_ch.frame_high_bits),
        .frame_low_bits   (in_ch.frame_low_bits),
        .message_kind     (in_ch.message_kind),
        .message_identity (in_ch.message_identity),
        .message_short_id (in_ch.message_short_id),
        .cfg_write        (cfg.valid),
        .cfg_identity     (cfg.permanent_identity),
        .result           (core_result)
    );

    // Result register
    hpr_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (item_accept),
        .result_in  (core_result),
        .out_ready  (out_ch.ready),
        .can_load   (can_load),
        .out_valid  (out_ch.valid),
        .result_out (held_result)
    );

    assign out_ch.send_tune         = held_result.send_tune;
    assign out_ch.send_registration = held_result.send_registration;
    assign out_ch.registered_event  = held_result.registered_event;
    assign out_ch.idle_event        = held_result.idle_event;
    assign out_ch.paged_event       = held_result.paged_event;
    assign out_ch.connection_state  = held_result.connection_state;
    assign out_ch.frame_count       = held_result.frame_count;
    assign out_ch.in_sync           = held_result.in_sync;

endmodule

### hw/rtl/hpr_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the receiver.
module hpr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          send_tune,
    input logic                          send_registration,
    input logic                          paged_event,
    input logic [hpr_pkg::MODE_W-1:0]    connection_state,
    input logic [hpr_pkg::FRAME_W-1:0]   frame_count,
    input logic                          in_sync
);

    // An accepted word always shows up as a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted word did not produce a result");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(frame_count) && $stable(connection_state)))
        else $error("stalled result changed");

    // Tuning is only requested while unsynchronised.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && send_tune) |-> !in_sync)
        else $error("tune request while in sync");

    // A registration request comes with the first sync, before registration.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && send_registration) |->
            (in_sync && connection_state == hpr_pkg::MODE_UNREG))
        else $error("registration request in wrong state");

    // Paging ends in the finished state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && paged_event) |-> (connection_state == hpr_pkg::MODE_DONE))
        else $error("paging event without finished state");

endmodule

bind handset_paging_receiver hpr_checker u_hpr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .send_tune         (out_ch.send_tune),
    .send_registration (out_ch.send_registration),
    .paged_event       (out_ch.paged_event),
    .connection_state  (out_ch.connection_state),
    .frame_count       (out_ch.frame_count),
    .in_sync           (out_ch.in_sync)
);

### sim/paging_result_checker.sv
`timescale 1ns / 1ps

module paging_result_checker #(
    parameter int RESYNC_INTERVAL = hpr_pkg::RESYNC_INTERVAL_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    hpr_in_if    in_ch,
    hpr_out_if   out_ch,
    hpr_cfg_if   cfg,
    output int   pending_count,
    output int   error_count
);
    import hpr_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Handset state as the block should hold it after every accepted word.
    logic                  synced_q;
    logic [FRAME_W-1:0]    frame_q;
    logic [TICK_W-1:0]     ticks_q;
    logic [MODE_W-1:0]     mode_q;
    logic                  request_sent_q;
    logic [SHORT_ID_W-1:0] short_id_q;
    logic                  deaf_q;
    logic [IDENT_W-1:0]    identity_q;

    // Result words still owed by the block, oldest first.
    result_t expected_words[$];

    function automatic string describe(result_t r);
        return $sformatf({"tune=%0b reg=%0b acc=%0b rel=%0b page=%0b ",
                          "state=%0d frame=%0d sync=%0b"},
                         r.send_tune, r.send_registration, r.registered_event,
                         r.idle_event, r.paged_event, r.connection_state,
                         r.frame_count, r.in_sync);
    endfunction

    // Apply one input word to the handset state and return the result word it causes.
    function automatic result_t advance_handset(
        input logic [OP_W-1:0]       op,
        input logic [FRAME_HI_W-1:0] high_bits,
        input logic [FRAME_LO_W-1:0] low_bits,
        input logic [KIND_W-1:0]     kind,
        input logic [IDENT_W-1:0]    ident,
        input logic [SID_W-1:0]      sid
    );
        result_t          r;
        logic [SID_W-1:0] own_sid;
        r = '0;
        own_sid = {{(SID_W - SHORT_ID_W){1'b0}}, short_id_q};
        // Once paged, the handset is finished and nothing changes any more.
        if (mode_q != MODE_DONE)
        begin
            if (op == OP_TICK)
            begin
                frame_q = frame_q + 1'b1;
                if (!synced_q)
                    r.send_tune = 1'b1;
                else if (int'(ticks_q) < RESYNC_INTERVAL)
                    ticks_q = ticks_q + 1'b1;
                // The idle handset stops listening late in the paging cycle.
                deaf_q = (mode_q == MODE_IDLE) && (frame_q[5:0] > DEAF_OFFSET_MIN)
                         && (int'(ticks_q) < RESYNC_INTERVAL);
            end
            else if (op == OP_SYNC && !deaf_q)
            begin
                if (!synced_q)
                begin
                    frame_q  = {high_bits, low_bits};
                    synced_q = 1'b1;
                    ticks_q  = '0;
                    if (!request_sent_q && mode_q == MODE_UNREG)
                    begin
                        r.send_registration = 1'b1;
                        request_sent_q      = 1'b1;
                    end
                end
                else if (int'(ticks_q) >= RESYNC_INTERVAL)
                begin
                    frame_q = {high_bits, low_bits};
                    ticks_q = '0;
                end
            end
            else if (op == OP_MESSAGE && !deaf_q)
            begin
                if (kind == KIND_ACCEPT)
                begin
                    if (ident == identity_q)
                    begin
                        short_id_q         = sid[SHORT_ID_W-1:0];
                        mode_q             = MODE_CONNECTED;
                        r.registered_event = 1'b1;
                    end
                end
                else if (kind == KIND_RELEASE)
                begin
                    if (sid == own_sid && mode_q == MODE_CONNECTED)
                    begin
                        mode_q       = MODE_IDLE;
                        r.idle_event = 1'b1;
                    end
                end
                else if (kind == KIND_PAGING)
                begin
                    if (mode_q == MODE_IDLE && sid == own_sid)
                    begin
                        mode_q        = MODE_DONE;
                        r.paged_event = 1'b1;
                    end
                end
            end
        end
        r.connection_state = mode_q;
        r.frame_count      = frame_q;
        r.in_sync          = synced_q;
        return r;
    endfunction

    // Watch all three channels; results are compared before new words are predicted.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        result_t next_word;
        if (!rst_n)
        begin
            synced_q       = 1'b0;
            frame_q        = '0;
            ticks_q        = '0;
            mode_q         = MODE_UNREG;
            request_sent_q = 1'b0;
            short_id_q     = '0;
            deaf_q         = 1'b0;
            identity_q     = '0;
            expected_words.delete();
            pending_count  = 0;
            error_count    = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                identity_q = cfg.permanent_identity;

            if (out_ch.valid && out_ch.ready)
            begin
                got = '{send_tune:         out_ch.send_tune,
                        send_registration: out_ch.send_registration,
                        registered_event:  out_ch.registered_event,
                        idle_event:        out_ch.idle_event,
                        paged_event:       out_ch.paged_event,
                        connection_state:  out_ch.connection_state,
                        frame_count:       out_ch.frame_count,
                        in_sync:           out_ch.in_sync};
                if (expected_words.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: result word with none expected: %s", $realtime,
                                 describe(got));
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: result word mismatch", $realtime);
                            $display("    expected %s", describe(want));
                            $display("    actual   %s", describe(got));
                        end
                    end
                end
            end

            if (in_ch.valid && in_ch.ready)
            begin
                next_word = advance_handset(in_ch.operation,
                                            in_ch.frame_high_bits,
                                            in_ch.frame_low_bits,
                                            in_ch.message_kind,
                                            in_ch.message_identity,
                                            in_ch.message_short_id);
                expected_words.insert(expected_words.size(), next_word);
            end
            pending_count = expected_words.size();
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import hpr_pkg::*;

    // Item kind that the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int HOLD_AFTER   = 400;
    localparam int LONG_HOLD    = 48;
    localparam int TAIL_START   = 1150;
    localparam int RANDOM_END   = 1210;

    logic clk;
    logic rst_n;

    hpr_in_if  in_ch();
    hpr_out_if out_ch();
    hpr_cfg_if cfg();

    int                 pending_count;
    int                 error_count;
    int                 sent_count;
    int                 gap_pct;
    int                 stall_pct;
    bit                 no_idle;
    bit                 long_hold_done;
    logic [IDENT_W-1:0] identity_now;
    logic [SID_W-1:0]   last_sid;

    handset_paging_receiver dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    paging_result_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg           (cfg),
        .pending_count (pending_count),
        .error_count   (error_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [IDENT_W-1:0] random_identity();
        return {$urandom, $urandom};
    endfunction

    // Offer one word, with an optional gap in front, and wait until it is taken.
    task automatic push_word(
        input logic [OP_W-1:0]       op,
        input logic [FRAME_HI_W-1:0] high_bits,
        input logic [FRAME_LO_W-1:0] low_bits,
        input logic [KIND_W-1:0]     kind,
        input logic [IDENT_W-1:0]    ident,
        input logic [SID_W-1:0]      sid
    );
        if (!no_idle && $urandom_range(0, 99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.operation        <= op;
        in_ch.frame_high_bits  <= high_bits;
        in_ch.frame_low_bits   <= low_bits;
        in_ch.message_kind     <= kind;
        in_ch.message_identity <= ident;
        in_ch.message_short_id <= sid;
        do @(posedge clk); while (!in_ch.ready);
        sent_count++;
        @(negedge clk);
    endtask

    // Unused fields carry random bits so the block has to ignore them.
    task automatic send_ticks(input int count);
        repeat (count)
            push_word(OP_TICK, FRAME_HI_W'($urandom), FRAME_LO_W'($urandom), $urandom,
                      random_identity(), $urandom);
    endtask

    task automatic send_sync(input logic [FRAME_HI_W-1:0] high_bits,
                             input logic [FRAME_LO_W-1:0] low_bits);
        push_word(OP_SYNC, high_bits, low_bits, $urandom, random_identity(), $urandom);
    endtask

    task automatic send_message(input logic [KIND_W-1:0]  kind,
                                input logic [IDENT_W-1:0] ident,
                                input logic [SID_W-1:0]   sid);
        push_word(OP_MESSAGE, FRAME_HI_W'($urandom), FRAME_LO_W'($urandom), kind, ident, sid);
    endtask

    // Stop offering and wait until every result word has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
    endtask

    // The identity is only changed while nothing is in flight.
    task automatic reprogram_identity(input logic [IDENT_W-1:0] value);
        drain_results();
        cfg.valid              <= 1'b1;
        cfg.permanent_identity <= value;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid    <= 1'b0;
        identity_now = value;
    endtask

    // Random traffic: tick runs, syncs, registration and release exchanges, paging and stray messages.
    // Paging always carries a nonzero upper half so it can never finish the handset.
    task automatic wander(input int target);
        int               choice;
        logic [SID_W-1:0] sid;
        logic [KIND_W-1:0] kind;
        while (sent_count < target)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    default: gap_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            choice = $urandom_range(0, 99);
            if (choice < 35)
                send_ticks($urandom_range(1, 24));
            else if (choice < 47)
                send_sync(FRAME_HI_W'($urandom), FRAME_LO_W'($urandom));
            else if (choice < 77)
            begin
                sid      = $urandom;
                last_sid = sid;
                send_message(KIND_ACCEPT, identity_now, sid);
                send_ticks($urandom_range(0, 3));
                send_message(KIND_RELEASE, random_identity(),
                             {{(SID_W - SHORT_ID_W){1'b0}}, sid[SHORT_ID_W-1:0]});
                send_ticks($urandom_range(0, 12));
            end
            else if (choice < 87)
            begin
                sid = $urandom;
                sid[SID_W-1:SHORT_ID_W] = (SID_W - SHORT_ID_W)'($urandom_range(1, 16'hFFFF));
                if ($urandom_range(0, 1) == 1)
                    sid[SHORT_ID_W-1:0] = last_sid[SHORT_ID_W-1:0];
                send_message(KIND_PAGING, random_identity(), sid);
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        kind = $urandom;
                        if (kind == KIND_PAGING)
                            kind = KIND_ACCEPT;
                        send_message(kind, random_identity(), $urandom);
                    end
                    1:       send_message(KIND_ACCEPT, random_identity(), $urandom);
                    default: send_message(KIND_RELEASE, random_identity(), $urandom);
                endcase
            end
        end
    endtask

    // Result side: random stall bursts and one long hold-off that backs up the block.
    initial
    begin
        out_ch.ready   = 1'b0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && sent_count >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (!no_idle && $urandom_range(0, 99) < stall_pct)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Input side: reset, directed opening, random phases under several identities,
    // then a closing exchange that pages the handset.
    initial
    begin
        logic [IDENT_W-1:0] phase_identity [4];
        logic [SID_W-1:0]   final_sid;

        rst_n                  = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.operation        = OP_TICK;
        in_ch.frame_high_bits  = '0;
        in_ch.frame_low_bits   = '0;
        in_ch.message_kind     = '0;
        in_ch.message_identity = '0;
        in_ch.message_short_id = '0;
        cfg.valid              = 1'b0;
        cfg.permanent_identity = '0;
        sent_count             = 0;
        gap_pct                = 20;
        stall_pct              = 20;
        no_idle                = 1'b0;
        identity_now           = '0;
        last_sid               = '0;

        phase_identity[0] = '0;
        phase_identity[1] = random_identity();
        phase_identity[2] = 64'h8000_0000_0000_0001;
        phase_identity[3] = random_identity();

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        reprogram_identity('1);

        // Before sync: ticks ask for tuning, messages find nothing to match.
        send_ticks(1);
        send_message(KIND_PAGING, '0, '0);
        send_message(KIND_ACCEPT, '0, 32'h0000_1234);
        push_word(OP_UNUSED, '1, '1, KIND_ACCEPT, '1, '1);
        // First sync adopts frame 54 and sends the registration request.
        send_sync(6'd3, 4'd6);
        send_message(32'hFFFF_FFFF, '1, '1);
        send_message(KIND_ACCEPT, '1, 32'hFFFF_FFFF);
        // Release compares all 32 bits against the zero-extended short identity.
        send_message(KIND_RELEASE, '1, 32'hFFFF_FFFF);
        send_message(KIND_RELEASE, '0, 32'h0000_FFFF);
        // Idle at offset 56 goes deaf: accept, sync and paging are all dropped.
        send_ticks(2);
        send_message(KIND_ACCEPT, '1, 32'h0000_0000);
        send_sync(6'h3F, 4'hF);
        send_message(KIND_PAGING, '0, 32'h0000_FFFF);
        // Wrapping to offset zero ends the deaf stretch.
        send_ticks(8);
        send_sync(6'h00, 4'h0);
        send_message(KIND_PAGING, '0, 32'h0001_FFFF);

        for (int p = 0; p < 4; p++)
        begin
            reprogram_identity(phase_identity[p]);
            if (p < 3)
                wander(TAIL_START * (p + 1) / 4 + 40);
            else
            begin
                wander(TAIL_START);
                no_idle = 1'b1;
                wander(RANDOM_END);
            end
        end

        // A tick may start or end a deaf stretch; retry until the paging lands.
        final_sid = $urandom;
        repeat (10)
        begin
            send_ticks(1);
            send_message(KIND_ACCEPT, identity_now, final_sid);
            send_message(KIND_RELEASE, random_identity(),
                         {{(SID_W - SHORT_ID_W){1'b0}}, final_sid[SHORT_ID_W-1:0]});
            send_message(KIND_PAGING, random_identity(),
                         {{(SID_W - SHORT_ID_W){1'b0}}, final_sid[SHORT_ID_W-1:0]});
        end
        // A finished handset ignores everything.
        send_ticks(2);
        send_sync(FRAME_HI_W'($urandom), FRAME_LO_W'($urandom));
        send_message(KIND_ACCEPT, identity_now, $urandom);

        drain_results();
        repeat (4) @(negedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### handset_paging_receiver.f
hw/rtl/hpr_pkg.sv
hw/rtl/hpr_if.sv
hw/rtl/hpr_core.sv
hw/rtl/hpr_result_reg.sv
hw/rtl/handset_paging_receiver.sv
hw/rtl/hpr_checker.sv
sim/paging_result_checker.sv
sim/testbench.sv
